FILE: hw/rtl/wtrem_pkg.sv
// shared constants of the wavetable tremolo: configuration port layout and register indexes
package wtrem_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgDepthTarget = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStepTarget  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWaveSelect  = 2'd2;

endpackage

FILE: hw/rtl/wtrem_in_if.sv
// input sample channel of the wavetable tremolo
interface wtrem_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          block_start;
  logic                          restart;

  modport source (output valid, output in_sample, output block_start, output restart,
                  input ready);
  modport sink (input valid, input in_sample, input block_start, input restart,
                output ready);
endinterface

FILE: hw/rtl/wtrem_out_if.sv
// output sample channel of the wavetable tremolo
interface wtrem_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

FILE: hw/rtl/wtrem_cfg_if.sv
// register write channel of the wavetable tremolo
interface wtrem_cfg_if;
  import wtrem_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/wavetable_tremolo.sv
// wavetable tremolo top level: lfo, smoothing divider and digit-serial gain multipliers
//
//   channel  dir  handshake          word
//   in_if    in   valid/ready        in_sample, block_start, restart
//   out_if   out  valid/ready        out_sample
//   cfg_if   in   valid/ready (=1)   index, data
//
// a word passes through the states prep, index, wave, first multiply, gain sum, second
// multiply and done before its result enters the output register, and no new word is taken
// until then; with block_start the bit-serial divide by ten and the smoothing update come first.
// the gain multiply runs 4-bit digits, first for the wave product and then for the sample.
// reset restores the control registers and the lfo at once, not the datapath registers;
// the sine table is constant logic. a new word is taken once the previous result has
// entered the output register, even while that result still waits on out_if.ready.
module wavetable_tremolo #(
  parameter int TABLE_LEN   = 2048,
  parameter int SAMPLE_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wtrem_in_if.sink    in_if,
  wtrem_out_if.source out_if,
  wtrem_cfg_if.sink   cfg_if
);
  import wtrem_pkg::*;

  localparam int IdxW      = $clog2(TABLE_LEN);
  localparam int ProdW     = 32 + IdxW;
  localparam int SB        = SAMPLE_BITS;
  localparam int Mul1Steps = 4;
  localparam int Mul2Steps = 8;
  localparam int DivSteps  = 32;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [16:0] UnityQ15  = 17'd32768;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StPrep   = 4'd1;
  localparam logic [3:0] StDiv    = 4'd2;
  localparam logic [3:0] StSmooth = 4'd3;
  localparam logic [3:0] StIdx    = 4'd4;
  localparam logic [3:0] StWave   = 4'd5;
  localparam logic [3:0] StMul1   = 4'd6;
  localparam logic [3:0] StGsum   = 4'd7;
  localparam logic [3:0] StMul2   = 4'd8;
  localparam logic [3:0] StDone   = 4'd9;

  // sine of 2*pi*i/TABLE_LEN in Q1.15 by a truncated taylor series
  function automatic logic signed [15:0] sine_entry(input int unsigned i);
    logic [31:0]        four;
    logic [31:0]        quad;
    logic [63:0]        r;
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    four = 32'(4 * i);
    quad = four / TABLE_LEN;
    r    = 64'(four % TABLE_LEN);
    if (quad[0]) r = 64'(TABLE_LEN) - r;
    a    = (HalfPiQ30 * r) / 64'(TABLE_LEN);
    a2   = (a * a) >> 30;
    term = a;
    sum  = signed'(a);
    term = ((term * a2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * a2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * a2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * a2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * a2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * a2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    if (sum < 0) sum = 0;
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) v = 64'sd32767;
    return (quad >= 32'd2) ? -16'(v) : 16'(v);
  endfunction

  logic signed [15:0] sine_tab [TABLE_LEN];

  for (genvar gi = 0; gi < TABLE_LEN; gi++) begin : g_sine
    assign sine_tab[gi] = sine_entry(gi);
  end

  // control state
  logic [3:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] depth_target_q, depth_target_d;
  logic [31:0] step_target_q, step_target_d;
  logic        wave_sel_q, wave_sel_d;
  logic [31:0] lfo_phase_q, lfo_phase_d;
  logic [15:0] depth_now_q, depth_now_d;
  logic [31:0] step_now_q, step_now_d;

  // datapath
  logic signed [SB-1:0] x_q, x_d;
  logic                 bs_q, bs_d;
  logic                 neg_s_q, neg_s_d;
  logic                 neg_d_q, neg_d_d;
  logic [31:0]          qs_q, qs_d;
  logic [15:0]          qd_q, qd_d;
  logic [3:0]           rs_q, rs_d;
  logic [3:0]           rd_q, rd_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic signed [16:0]   w_q, w_d;
  logic [15:0]          m_q, m_d;
  logic signed [17:0]   acc1_q, acc1_d;
  logic [15:0]          lo1_q, lo1_d;
  logic [31:0]          g_q, g_d;
  logic signed [SB:0]   acc2_q, acc2_d;
  logic [31:0]          lo2_q, lo2_d;
  logic signed [SB-1:0] out_sample_q, out_sample_d;

  logic [15:0]          depth_goal;
  logic [32:0]          ds;
  logic [16:0]          dd;
  logic [4:0]           div_s;
  logic [4:0]           div_d;
  logic [ProdW-1:0]     idx_prod;
  logic                 sq_pos;
  logic signed [21:0]   sum1;
  logic signed [SB+4:0] sum2;
  logic signed [SB+1:0] y;
  logic [33:0]          p1;

  assign in_if.ready  = (state_q == StIdle);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid      = out_valid_q;
  assign out_if.out_sample = out_sample_q;

  assign depth_goal = ({1'b0, depth_target_q} > UnityQ15) ? UnityQ15[15:0] : depth_target_q;
  assign ds    = {1'b0, step_target_q} - {1'b0, step_now_q};
  assign dd    = {1'b0, depth_goal} - {1'b0, depth_now_q};
  assign div_s = {rs_q, qs_q[31]};
  assign div_d = {rd_q, qd_q[15]};
  assign idx_prod = ProdW'(lfo_phase_q) * ProdW'(TABLE_LEN);
  assign sq_pos   = (idx_q != '0) && (({1'b0, idx_q} << 1) < (IdxW+1)'(TABLE_LEN));
  assign sum1 = 22'(acc1_q) + w_q * signed'({1'b0, m_q[3:0]});
  assign sum2 = (SB+5)'(acc2_q) + x_q * signed'({1'b0, g_q[3:0]})
              + ((cnt_q == 5'(Mul2Steps - 1)) ? (SB+5)'(4) : (SB+5)'(0));
  assign p1 = {acc1_q, lo1_q};
  assign y  = {acc2_q, lo2_q[31]};

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    out_valid_d    = out_valid_q;
    depth_target_d = depth_target_q;
    step_target_d  = step_target_q;
    wave_sel_d     = wave_sel_q;
    lfo_phase_d    = lfo_phase_q;
    depth_now_d    = depth_now_q;
    step_now_d     = step_now_q;
    x_d            = x_q;
    bs_d           = bs_q;
    neg_s_d        = neg_s_q;
    neg_d_d        = neg_d_q;
    qs_d           = qs_q;
    qd_d           = qd_q;
    rs_d           = rs_q;
    rd_d           = rd_q;
    idx_d          = idx_q;
    w_d            = w_q;
    m_d            = m_q;
    acc1_d         = acc1_q;
    lo1_d          = lo1_q;
    g_d            = g_q;
    acc2_d         = acc2_q;
    lo2_d          = lo2_q;
    out_sample_d   = out_sample_q;

    if (out_valid_q && out_if.ready) out_valid_d = 1'b0;

    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CfgDepthTarget: depth_target_d = cfg_if.data[15:0];
        CfgStepTarget:  step_target_d  = cfg_if.data[31:0];
        CfgWaveSelect:  wave_sel_d     = cfg_if.data[0];
        default: ;
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (in_if.valid) begin
          x_d  = in_if.in_sample;
          bs_d = in_if.block_start;
          if (in_if.restart) begin
            lfo_phase_d = '0;
            depth_now_d = depth_goal;
            step_now_d  = step_target_q;
          end
          state_d = StPrep;
        end
      end
      StPrep: begin
        neg_s_d = ds[32];
        neg_d_d = dd[16];
        qs_d    = ds[32] ? 32'(-ds) : ds[31:0];
        qd_d    = dd[16] ? 16'(-dd) : dd[15:0];
        rs_d    = '0;
        rd_d    = '0;
        cnt_d   = '0;
        state_d = bs_q ? StDiv : StIdx;
      end
      StDiv: begin
        // restoring divide by ten, one quotient bit a cycle
        if (div_s >= 5'd10) begin
          rs_d = 4'(div_s - 5'd10);
          qs_d = {qs_q[30:0], 1'b1};
        end else begin
          rs_d = div_s[3:0];
          qs_d = {qs_q[30:0], 1'b0};
        end
        if (!cnt_q[4]) begin
          if (div_d >= 5'd10) begin
            rd_d = 4'(div_d - 5'd10);
            qd_d = {qd_q[14:0], 1'b1};
          end else begin
            rd_d = div_d[3:0];
            qd_d = {qd_q[14:0], 1'b0};
          end
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DivSteps - 1)) state_d = StSmooth;
      end
      StSmooth: begin
        step_now_d  = neg_s_q ? step_now_q - qs_q : step_now_q + qs_q;
        depth_now_d = neg_d_q ? depth_now_q - qd_q : depth_now_q + qd_q;
        state_d     = StIdx;
      end
      StIdx: begin
        idx_d   = idx_prod[32 +: IdxW];
        state_d = StWave;
      end
      StWave: begin
        if (wave_sel_q) begin
          w_d = sq_pos ? signed'(UnityQ15) : -signed'(UnityQ15);
        end else begin
          w_d = {sine_tab[idx_q][15], sine_tab[idx_q]};
        end
        lfo_phase_d = lfo_phase_q + step_now_q;
        m_d     = 16'(UnityQ15 - {1'b0, depth_now_q});
        acc1_d  = '0;
        lo1_d   = '0;
        cnt_d   = '0;
        state_d = StMul1;
      end
      StMul1: begin
        acc1_d = sum1[21:4];
        lo1_d  = {sum1[3:0], lo1_q[15:4]};
        m_d    = {4'b0, m_q[15:4]};
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'(Mul1Steps - 1)) state_d = StGsum;
      end
      StGsum: begin
        g_d     = 32'h4000_0000 + {1'b0, depth_now_q, 15'b0} + p1[31:0];
        acc2_d  = '0;
        lo2_d   = '0;
        cnt_d   = '0;
        state_d = StMul2;
      end
      StMul2: begin
        acc2_d = sum2[SB+4:4];
        lo2_d  = {sum2[3:0], lo2_q[31:4]};
        g_d    = {4'b0, g_q[31:4]};
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'(Mul2Steps - 1)) state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_if.ready) begin
          if ((y[SB+1] == y[SB]) && (y[SB] == y[SB-1])) begin
            out_sample_d = y[SB-1:0];
          end else begin
            out_sample_d = {y[SB+1], {(SB-1){~y[SB+1]}}};
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
      depth_target_q <= UnityQ15[15:0];
      step_target_q  <= '0;
      wave_sel_q     <= 1'b0;
      lfo_phase_q    <= '0;
      depth_now_q    <= UnityQ15[15:0];
      step_now_q     <= '0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      out_valid_q    <= out_valid_d;
      depth_target_q <= depth_target_d;
      step_target_q  <= step_target_d;
      wave_sel_q     <= wave_sel_d;
      lfo_phase_q    <= lfo_phase_d;
      depth_now_q    <= depth_now_d;
      step_now_q     <= step_now_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    bs_q         <= bs_d;
    neg_s_q      <= neg_s_d;
    neg_d_q      <= neg_d_d;
    qs_q         <= qs_d;
    qd_q         <= qd_d;
    rs_q         <= rs_d;
    rd_q         <= rd_d;
    idx_q        <= idx_d;
    w_q          <= w_d;
    m_q          <= m_d;
    acc1_q       <= acc1_d;
    lo1_q        <= lo1_d;
    g_q          <= g_d;
    acc2_q       <= acc2_d;
    lo2_q        <= lo2_d;
    out_sample_q <= out_sample_d;
  end

endmodule

FILE: bench/wtrem_checker.sv
// checker of the wavetable tremolo: predicts every output word and compares it on arrival
`timescale 1ns / 1ps
module wtrem_checker #(
  parameter int TABLE_LEN   = 2048,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_i,
  input  logic                               block_start_i,
  input  logic                               restart_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0]      out_sample_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [wtrem_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [wtrem_pkg::CfgDataW-1:0]     cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint Unity = 32768;
  localparam longint SampleMax = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SampleMin = -SampleMax - 1;
  localparam int MaxReports = 20;

  logic signed [15:0]            sine_q15 [TABLE_LEN];
  logic [15:0]                   depth_tgt = 16'd32768;
  logic [15:0]                   depth_now = 16'd32768;
  logic [31:0]                   step_tgt = '0;
  logic [31:0]                   step_now = '0;
  logic [31:0]                   lfo_phase = '0;
  logic                          square_sel = 1'b0;
  logic signed [SAMPLE_BITS-1:0] modulated_q [$];
  logic signed [SAMPLE_BITS-1:0] want;
  int                            fails = 0;

  function automatic logic signed [15:0] sine_value(int unsigned i);
    longint unsigned quad, rem, ang, ang2, term;
    longint sum, v;
    int k;
    quad = (4 * i) / TABLE_LEN;
    rem  = (4 * i) % TABLE_LEN;
    if (quad[0]) rem = TABLE_LEN - rem;
    ang  = HalfPiQ30 * rem / TABLE_LEN;
    ang2 = (ang * ang) >> 30;
    term = ang;
    sum  = longint'(ang);
    for (k = 1; k <= 6; k++) begin
      term = ((term * ang2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (sum + 16384) >>> 15;
    if (v > 32767) v = 32767;
    return (quad >= 2) ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [15:0] depth_cap(logic [15:0] t);
    return (t > 16'd32768) ? 16'd32768 : t;
  endfunction

  // advances the lfo state by one word and returns the scaled sample
  function automatic logic signed [SAMPLE_BITS-1:0] modulate(
      logic signed [SAMPLE_BITS-1:0] smp, logic bstart, logic rst_lfo);
    longint x, dd, ds, w, c, g, y;
    logic [31:0] idx;
    x = smp;
    if (rst_lfo) begin
      lfo_phase = '0;
      depth_now = depth_cap(depth_tgt);
      step_now  = step_tgt;
    end
    if (bstart) begin
      dd = longint'(depth_cap(depth_tgt)) - longint'(depth_now);
      ds = longint'(step_tgt) - longint'(step_now);
      depth_now = 16'(longint'(depth_now) + dd / 10);
      step_now  = 32'(longint'(step_now) + ds / 10);
    end
    idx = 32'((longint'(lfo_phase) * TABLE_LEN) >> 32);
    if (square_sel) w = (idx > 0 && 2 * idx < TABLE_LEN) ? Unity : -Unity;
    else w = sine_q15[idx];
    c = depth_now;
    g = (Unity + c) * Unity + (Unity - c) * w;
    y = (x * g + 64'sd1073741824) >>> 31;
    if (y > SampleMax) y = SampleMax;
    if (y < SampleMin) y = SampleMin;
    lfo_phase = lfo_phase + step_now;
    return y[SAMPLE_BITS-1:0];
  endfunction

  initial begin
    for (int i = 0; i < TABLE_LEN; i++) sine_q15[i] = sine_value(i);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_tgt   = 16'd32768;
      step_tgt    = '0;
      square_sel  = 1'b0;
      lfo_phase   = '0;
      depth_now   = 16'd32768;
      step_now    = '0;
      modulated_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (modulated_q.size() == 0) begin
          fails++;
          if (fails <= MaxReports)
            $error("out_sample: expected none, actual %0d", out_sample_i);
        end else begin
          want = modulated_q.pop_front();
          if (out_sample_i !== want) begin
            fails++;
            if (fails <= MaxReports)
              $error("out_sample: expected %0d, actual %0d", want, out_sample_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          wtrem_pkg::CfgDepthTarget: depth_tgt = cfg_data_i[15:0];
          wtrem_pkg::CfgStepTarget:  step_tgt = cfg_data_i[31:0];
          wtrem_pkg::CfgWaveSelect:  square_sel = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        modulated_q.push_back(modulate(in_sample_i, block_start_i, restart_i));
      pending_o <= modulated_q.size();
    end
    fail_count_o <= fails;
  end

endmodule

FILE: bench/tb_wavetable_tremolo.sv
// testbench top of the wavetable tremolo: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps
module tb_wavetable_tremolo;
  import wtrem_pkg::*;

  localparam int TableLen      = 2048;
  localparam int SampleBits    = 24;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles  = 60;
  localparam int WordsPerPhase = 120;
  localparam int Phases        = 8;
  localparam logic signed [SampleBits-1:0] SampleMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic signed [SampleBits-1:0] SampleMin = {1'b1, {(SampleBits-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending_words;
  int   quiet_cycles = 0;
  bit   send_idle = 1'b0;
  bit   take_idle = 1'b0;
  bit   hold_req = 1'b0;

  wtrem_in_if  #(.SAMPLE_BITS(SampleBits)) in_if ();
  wtrem_out_if #(.SAMPLE_BITS(SampleBits)) out_if ();
  wtrem_cfg_if cfg_if ();

  wavetable_tremolo #(
    .TABLE_LEN  (TableLen),
    .SAMPLE_BITS(SampleBits)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  wtrem_checker #(
    .TABLE_LEN  (TableLen),
    .SAMPLE_BITS(SampleBits)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_sample_i  (in_if.in_sample),
    .block_start_i(in_if.block_start),
    .restart_i    (in_if.restart),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_sample_i (out_if.out_sample),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_index_i  (cfg_if.index),
    .cfg_data_i   (cfg_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
  endfunction

  function automatic logic signed [SampleBits-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SampleMax;
      1: return SampleMin;
      2: return '0;
      3: return '1;
      default: return SampleBits'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_depth();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0080_0000);
    endcase
  endfunction

  task automatic send_word(logic signed [SampleBits-1:0] smp, logic bstart, logic rst_lfo);
    in_if.valid       <= 1'b1;
    in_if.in_sample   <= smp;
    in_if.block_start <= bstart;
    in_if.restart     <= rst_lfo;
    do @(posedge clk); while (!in_if.ready);
    if (send_idle && $urandom_range(0, 2) == 0) begin
      in_if.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // one host block: smoothing on its first word, stray flags as noise
  task automatic send_block(int len);
    logic rst_lfo;
    rst_lfo = ($urandom_range(0, 15) == 0);
    for (int n = 0; n < len; n++)
      send_word(pick_sample(), (n == 0) || ($urandom_range(0, 63) == 0),
                (n == 0) ? rst_lfo : ($urandom_range(0, 255) == 0));
  endtask

  task automatic wait_drained();
    if (in_if.valid) in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  task automatic put_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic configure(logic [15:0] depth, logic [31:0] step, logic wave, bit poke);
    put_reg(CfgDepthTarget, {16'($urandom), depth});
    put_reg(CfgStepTarget, step);
    put_reg(CfgWaveSelect, {31'($urandom), wave});
    if (poke) put_reg(CfgUnused, $urandom);
    cfg_if.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (take_idle && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    int words;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.in_sample   <= '0;
    in_if.block_start <= 1'b0;
    in_if.restart     <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unity depth after reset passes samples through
    send_word(SampleMax, 1'b0, 1'b0);
    send_word(SampleMin, 1'b1, 1'b0);
    send_word(24'sd1, 1'b0, 1'b0);
    wait_drained();

    // square wave at full depth: index zero, quarter, midpoint, three quarters
    configure(16'd0, 32'h4000_0000, 1'b1, 1'b1);
    send_word(SampleMax, 1'b0, 1'b1);
    send_word(SampleMax, 1'b0, 1'b0);
    send_word(SampleMin, 1'b0, 1'b0);
    send_word(SampleMax, 1'b0, 1'b0);
    send_word('1, 1'b1, 1'b0);
    send_word('0, 1'b0, 1'b0);
    wait_drained();

    // depth above unity, top step, smoothing with and without restart
    configure(16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(SampleMax, 1'b1, 1'b0);
    send_word(SampleMin, 1'b1, 1'b0);
    send_word(24'sd1000000, 1'b0, 1'b0);
    send_word(SampleMin, 1'b1, 1'b1);
    send_word(SampleMax, 1'b0, 1'b0);
    send_word(-24'sd3, 1'b0, 1'b1);
    wait_drained();

    configure(16'd32768, 32'h0000_1000, 1'b0, 1'b0);
    send_word(SampleMax, 1'b1, 1'b0);
    send_word(SampleMin, 1'b1, 1'b0);
    send_word(24'sd4660, 1'b0, 1'b1);

    for (int ph = 0; ph < Phases; ph++) begin
      wait_drained();
      configure(pick_depth(), pick_step(), 1'($urandom), $urandom_range(0, 2) == 0);
      send_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
      take_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
      words = 0;
      if (ph == 2) begin
        // output held off while words keep coming
        send_idle = 1'b0;
        hold_req = 1'b1;
        send_block(24);
        words += 24;
        send_idle = 1'b1;
      end
      if (ph == 4) begin
        send_block(30);
        words += 30;
        wait_drained();
      end
      while (words < WordsPerPhase) begin
        int len;
        len = $urandom_range(1, 40);
        send_block(len);
        words += len;
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && pending_words == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
